@@ hw/rtl/ocpc_pkg.sv @@
// Package for the ones' complement packet checksum block.
// Holds widths, the pipeline stage type and the ones' complement helpers.
// No dependencies.
package ocpc_pkg;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int SEED_W = 32;
  localparam int POS_W  = 16;

  localparam logic [BYTE_W-1:0] PAD_BYTE  = 8'h00;
  localparam logic [WORD_W-1:0] ZERO_WORD = 16'h0000;
  localparam logic [WORD_W-1:0] ONES_WORD = 16'hFFFF;

  // Registered input transaction. The seed is already half folded.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic [WORD_W:0]   seed_part;
    logic [POS_W-1:0]  skip_offset;
  } stage_t;

  // Result register contents handed back to the top level.
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] checksum_value;
  } result_t;

  // Adds the carry of a 17-bit partial sum back into the low 16 bits.
  // For sums of two 16-bit values this never produces a further carry.
  function automatic logic [WORD_W-1:0] oc_fold(input logic [WORD_W:0] s);
    return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
  endfunction

  function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return oc_fold(s);
  endfunction

endpackage

@@ hw/rtl/ocpc_if.sv @@
// Valid/ready channel interfaces for the ones' complement packet checksum.
// Depends on ocpc_pkg for field widths.
interface ocpc_in_if;
  logic                         valid;
  logic                         ready;
  logic [ocpc_pkg::BYTE_W-1:0]  data_byte;
  logic                         last_byte;
  logic [ocpc_pkg::SEED_W-1:0]  seed_sum;
  logic [ocpc_pkg::POS_W-1:0]   skip_offset;

  modport source (output valid, data_byte, last_byte, seed_sum, skip_offset,
                  input ready);
  modport sink (input valid, data_byte, last_byte, seed_sum, skip_offset,
                output ready);
endinterface

interface ocpc_out_if;
  logic                         valid;
  logic                         ready;
  logic [ocpc_pkg::WORD_W-1:0]  checksum_value;

  modport source (output valid, checksum_value, input ready);
  modport sink (input valid, checksum_value, output ready);
endinterface

@@ hw/rtl/ocpc_accum.sv @@
// Checksum accumulator: packet state, word pairing, skip match and result register.
// Depends on ocpc_pkg.
module ocpc_accum (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  ocpc_pkg::stage_t        item,
  output ocpc_pkg::result_t       result
);

  logic [ocpc_pkg::WORD_W-1:0] running_sum, running_sum_next;
  logic [ocpc_pkg::POS_W-1:0]  byte_position;
  logic [ocpc_pkg::BYTE_W-1:0] held_high_byte;
  logic [ocpc_pkg::POS_W-1:0]  latched_skip;
  logic                        in_packet;
  logic                        out_valid;
  logic [ocpc_pkg::WORD_W-1:0] checksum;

  logic [ocpc_pkg::WORD_W-1:0] base_sum;
  logic [ocpc_pkg::POS_W-1:0]  skip_cur;
  logic [ocpc_pkg::POS_W-1:0]  pos_cur;
  logic [ocpc_pkg::WORD_W-1:0] word;
  logic                        skip_hit;
  logic                        add_en;

  always_comb begin
    base_sum = in_packet ? running_sum : ocpc_pkg::oc_fold(item.seed_part);
    skip_cur = in_packet ? latched_skip : item.skip_offset;
    pos_cur  = in_packet ? byte_position : '0;
    // A word always starts at an even offset, so an odd skip never matches.
    skip_hit = (pos_cur[ocpc_pkg::POS_W-1:1] == skip_cur[ocpc_pkg::POS_W-1:1]) &&
               !skip_cur[0];
    word     = pos_cur[0] ? {held_high_byte, item.data_byte}
                          : {item.data_byte, ocpc_pkg::PAD_BYTE};
    // An even-offset byte adds only when it is the padded trailing byte.
    add_en   = !skip_hit && (pos_cur[0] || item.last_byte);
    running_sum_next = add_en ? ocpc_pkg::oc_add(base_sum, word) : base_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= ocpc_pkg::ZERO_WORD;
      byte_position  <= '0;
      held_high_byte <= ocpc_pkg::PAD_BYTE;
      latched_skip   <= '0;
      in_packet      <= 1'b0;
      out_valid      <= 1'b0;
    end else if (advance) begin
      out_valid <= item.valid && item.last_byte;
      if (item.valid) begin
        if (item.last_byte) begin
          running_sum    <= ocpc_pkg::ZERO_WORD;
          byte_position  <= '0;
          held_high_byte <= ocpc_pkg::PAD_BYTE;
          latched_skip   <= '0;
          in_packet      <= 1'b0;
        end else begin
          running_sum   <= running_sum_next;
          byte_position <= pos_cur + 1'b1;
          latched_skip  <= skip_cur;
          in_packet     <= 1'b1;
          if (!pos_cur[0]) begin
            held_high_byte <= item.data_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.valid && item.last_byte) begin
      checksum <= running_sum_next ^ ocpc_pkg::ONES_WORD;
    end
  end

  assign result.valid          = out_valid;
  assign result.checksum_value = checksum;

endmodule

@@ hw/rtl/ones_complement_packet_checksum.sv @@
// Internet checksum over a byte stream: one byte per transaction, one result per packet.
// A last byte is captured in the input register, then its result in the result register.
// Throughput: one byte per cycle while the result side is not stalled; the input register and the 16-bit ones'
// complement add on the packet state set the figure.
// Synchronous active-high reset empties both stages and returns to packet start.
// Depends on ocpc_pkg, ocpc_if and ocpc_accum.
module ones_complement_packet_checksum (
  input  logic        clk,
  input  logic        rst,
  ocpc_in_if.sink     pkt,
  ocpc_out_if.source  csum
);

  ocpc_pkg::stage_t  in_stage;
  ocpc_pkg::result_t result;
  logic              advance;
  logic              in_fire;

  assign advance   = !result.valid || csum.ready;
  assign pkt.ready = !in_stage.valid || advance;
  assign in_fire   = pkt.valid && pkt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_stage.valid <= 1'b0;
    end else if (pkt.ready) begin
      in_stage.valid <= pkt.valid;
    end
    // First half of the seed fold happens on the way into the input register.
    if (in_fire) begin
      in_stage.data_byte   <= pkt.data_byte;
      in_stage.last_byte   <= pkt.last_byte;
      in_stage.seed_part   <= {1'b0, pkt.seed_sum[ocpc_pkg::WORD_W-1:0]} +
                              {1'b0, pkt.seed_sum[ocpc_pkg::SEED_W-1:ocpc_pkg::WORD_W]};
      in_stage.skip_offset <= pkt.skip_offset;
    end
  end

  ocpc_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_stage),
    .result  (result)
  );

  assign csum.valid          = result.valid;
  assign csum.checksum_value = result.checksum_value;

endmodule

@@ hw/rtl/ocpc_checker.sv @@
// Port-level checker for the ones' complement packet checksum, with its bind.
// Depends on ocpc_pkg; attached to ones_complement_packet_checksum.
module ocpc_port_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ocpc_pkg::WORD_W-1:0] out_value
);

  // Packets whose last byte is accepted but whose checksum is not yet taken.
  logic [1:0] pending;
  logic       last_fire;
  logic       out_fire;

  assign last_fire = in_valid && in_ready && in_last;
  assign out_fire  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else if (last_fire && !out_fire) begin
      pending <= pending + 2'd1;
    end else if (!last_fire && out_fire) begin
      pending <= pending - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("checksum changed or dropped while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("checksum transaction without a finished packet");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more finished packets in flight than pipeline stages");

endmodule

bind ones_complement_packet_checksum ocpc_port_checker u_ocpc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pkt.valid),
  .in_ready  (pkt.ready),
  .in_last   (pkt.last_byte),
  .out_valid (csum.valid),
  .out_ready (csum.ready),
  .out_value (csum.checksum_value)
);

@@ bench/ocpc_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the ones' complement packet checksum: watches both channels,
// predicts each packet's checksum and compares it with the returned one.
// Depends on ocpc_pkg for widths and on the ocpc_in_if / ocpc_out_if channels.
module ocpc_checker (
  input  logic clk,
  input  logic rst,
  ocpc_in_if   pkt_mon,
  ocpc_out_if  sum_mon,
  output int   fail_count,
  output int   results_checked,
  output int   pending
);

  localparam int REPORT_LIMIT = 10;

  logic [ocpc_pkg::WORD_W-1:0] checksum_expected [$];

  // Packet state of the checksum predictor.
  logic [ocpc_pkg::WORD_W-1:0] acc_sum;
  logic [ocpc_pkg::POS_W-1:0]  byte_pos;
  logic [ocpc_pkg::POS_W-1:0]  skip_at;
  logic [ocpc_pkg::BYTE_W-1:0] high_byte;
  logic                        mid_packet;
  int                          mismatches;
  int                          checked;

  function automatic logic [ocpc_pkg::WORD_W-1:0] wrap_add(
      input logic [ocpc_pkg::WORD_W-1:0] a,
      input logic [ocpc_pkg::WORD_W-1:0] b);
    logic [ocpc_pkg::WORD_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[ocpc_pkg::WORD_W-1:0] +
           {{(ocpc_pkg::WORD_W-1){1'b0}}, t[ocpc_pkg::WORD_W]};
  endfunction

  task automatic clear_packet();
    acc_sum    = ocpc_pkg::ZERO_WORD;
    byte_pos   = '0;
    skip_at    = '0;
    high_byte  = ocpc_pkg::PAD_BYTE;
    mid_packet = 1'b0;
  endtask

  task automatic absorb_byte(input logic [ocpc_pkg::BYTE_W-1:0] b, input logic last,
                             input logic [ocpc_pkg::SEED_W-1:0] seed,
                             input logic [ocpc_pkg::POS_W-1:0] skip);
    logic [ocpc_pkg::WORD_W:0]  half;
    logic [ocpc_pkg::POS_W-1:0] word_start;
    if (!mid_packet) begin
      // Fold the 32-bit seed; the second carry add cannot overflow.
      half       = {1'b0, seed[ocpc_pkg::WORD_W-1:0]} +
                   {1'b0, seed[ocpc_pkg::SEED_W-1:ocpc_pkg::WORD_W]};
      acc_sum    = half[ocpc_pkg::WORD_W-1:0] +
                   {{(ocpc_pkg::WORD_W-1){1'b0}}, half[ocpc_pkg::WORD_W]};
      skip_at    = skip;
      byte_pos   = '0;
      mid_packet = 1'b1;
    end
    if (!byte_pos[0]) begin
      high_byte = b;
      // A lone trailing byte is padded low with zero.
      if (last && byte_pos != skip_at)
        acc_sum = wrap_add(acc_sum, {b, ocpc_pkg::PAD_BYTE});
    end else begin
      word_start = byte_pos - 1'b1;
      if (word_start != skip_at)
        acc_sum = wrap_add(acc_sum, {high_byte, b});
    end
    byte_pos = byte_pos + 1'b1;
    if (last) begin
      checksum_expected.push_back(~acc_sum);
      clear_packet();
    end
  endtask

  task automatic report(input string what);
    if (mismatches < REPORT_LIMIT)
      $display("[%0t] %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_packet();
      checksum_expected.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (pkt_mon.valid && pkt_mon.ready)
        absorb_byte(pkt_mon.data_byte, pkt_mon.last_byte, pkt_mon.seed_sum,
                    pkt_mon.skip_offset);
      if (sum_mon.valid && sum_mon.ready) begin
        if (checksum_expected.size() == 0) begin
          report($sformatf("unexpected checksum %h with no packet outstanding",
                           sum_mon.checksum_value));
        end else begin
          if (sum_mon.checksum_value !== checksum_expected[0])
            report($sformatf("checksum mismatch: expected %h, got %h",
                             checksum_expected[0], sum_mon.checksum_value));
          void'(checksum_expected.pop_front());
          checked++;
        end
      end
    end
    fail_count      <= mismatches;
    results_checked <= checked;
    pending         <= checksum_expected.size();
  end

endmodule

@@ bench/tb_ones_complement_packet_checksum.sv @@
`timescale 1ns / 100ps
// Top of the checksum testbench: clock, reset, packet stimulus, result-side
// back-pressure, watchdog and verdict. Depends on ocpc_pkg, the channel
// interfaces, ocpc_checker and the ones_complement_packet_checksum block.
module tb_ones_complement_packet_checksum;

  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int RANDOM_BYTES  = 750;
  localparam int MAX_GAP       = 18;

  typedef logic [ocpc_pkg::BYTE_W-1:0] byte_t;
  typedef logic [ocpc_pkg::SEED_W-1:0] seed_t;
  typedef logic [ocpc_pkg::POS_W-1:0]  pos_t;
  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   results_checked;
  int   pending;
  int   idle_cycles;
  int   packets_sent;
  int   bytes_sent;
  bit   steady;

  ocpc_in_if  pkt_ch ();
  ocpc_out_if sum_ch ();

  ones_complement_packet_checksum u_dut (
    .clk  (clk),
    .rst  (rst),
    .pkt  (pkt_ch),
    .csum (sum_ch)
  );

  ocpc_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .pkt_mon         (pkt_ch),
    .sum_mon         (sum_ch),
    .fail_count      (fail_count),
    .results_checked (results_checked),
    .pending         (pending)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int draw_gap();
    if (steady || $urandom_range(0, 3) == 0)
      return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input byte_t b, input logic last,
                           input seed_t seed, input pos_t skip);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      pkt_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pkt_ch.valid       <= 1'b1;
    pkt_ch.data_byte   <= b;
    pkt_ch.last_byte   <= last;
    pkt_ch.seed_sum    <= seed;
    pkt_ch.skip_offset <= skip;
    do @(posedge clk); while (!pkt_ch.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Seed and skip only matter on the first byte; later bytes carry noise there.
  task automatic send_packet(input int len, input fill_t fill,
                             input seed_t seed, input pos_t skip);
    byte_t b;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ONES:  b = 8'hFF;
        FILL_ZEROS: b = 8'h00;
        default:    b = byte_t'($urandom_range(0, 255));
      endcase
      if (i == 0)
        send_byte(b, len == 1, seed, skip);
      else
        send_byte(b, i == len - 1, $urandom, pos_t'($urandom_range(0, 65535)));
    end
    packets_sent++;
  endtask

  function automatic seed_t pick_seed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {16'h0000, 16'hFFFF};
      default: return $urandom;
    endcase
  endfunction

  function automatic pos_t pick_skip(input int len);
    case ($urandom_range(0, 4))
      0, 1:    return pos_t'($urandom_range(0, len - 1) & ~1);
      2:       return pos_t'($urandom_range(0, len));
      3:       return pos_t'($urandom_range(0, 65535));
      default: return '0;
    endcase
  endfunction

  // Result side: a freshly drawn stall, possibly none, before every checksum transaction.
  initial begin
    int stall;
    sum_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        sum_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      sum_ch.ready <= 1'b1;
      do @(posedge clk); while (!sum_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (pkt_ch.valid && pkt_ch.ready) || (sum_ch.valid && sum_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d checksums outstanding",
               IDLE_LIMIT, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int len;
    rst                = 1'b1;
    packets_sent       = 0;
    bytes_sent         = 0;
    steady             = 1'b0;
    pkt_ch.valid       = 1'b0;
    pkt_ch.data_byte   = '0;
    pkt_ch.last_byte   = 1'b0;
    pkt_ch.seed_sum    = '0;
    pkt_ch.skip_offset = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: single bytes with and without a skip, odd skips, a skipped
    // trailing pad byte, a skip past the end and seed carry overflow.
    send_packet(1, FILL_ONES,   32'hFFFF_FFFF, 16'd0);
    send_packet(1, FILL_ONES,   32'h0000_0000, 16'd1);
    send_packet(2, FILL_ZEROS,  32'h0000_0000, 16'hFFFF);
    send_packet(2, FILL_ONES,   32'h0001_FFFF, 16'd0);
    send_packet(3, FILL_RANDOM, $urandom,      16'd2);
    send_packet(4, FILL_ONES,   32'h0000_0000, 16'd3);
    send_packet(5, FILL_RANDOM, 32'hFFFF_0000, 16'd8);
    send_packet(6, FILL_RANDOM, 32'h0000_0000, 16'd4);

    // Random packets, mostly short, with occasional stretches of no idling.
    while (bytes_sent < RANDOM_BYTES) begin
      steady = ($urandom_range(0, 4) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                        : $urandom_range(1, 40);
      send_packet(len, FILL_RANDOM, pick_seed(), pick_skip(len));
    end
    steady = 1'b0;
    pkt_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d packets (%0d bytes) with random idling and back-to-back bursts.",
             packets_sent, bytes_sent);
    $display("Compared %0d checksums, %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
